[rtl/core/mtld_pkg.sv]
// Shared types and constants for the message type/length deframer.
package mtld_pkg;

   typedef enum logic [2:0] {
      PH_HEAD0,
      PH_HEAD1,
      PH_LEN,
      PH_BODY,
      PH_HALT
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_MISMATCH,
      ST_UNKNOWN,
      ST_DROPPED
   } status_type;

   localparam int BYTE_W     = 8;
   localparam int SIZE_W     = 16;
   localparam int BODY_W     = 32;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [BYTE_W-1:0] msg_type;
      logic              first_of_msg;
      logic              last_of_msg;
      status_type        status;
   } rsp_type;

   typedef struct packed {
      logic              known;
      logic              variable;
      logic [SIZE_W-1:0] size;
   } desc_type;

   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] id;
   } tbl_rd_type;

   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] id;
      desc_type          desc;
   } tbl_wr_type;

endpackage

[rtl/core/message_type_length_deframer.sv]
// Top level of the message type/length deframer.
//
// Takes one beat per clock, data bytes and descriptor writes alike, with no
// stall of its own: ready drops only while the 4-beat result queue has fewer
// than two free slots, so with rsp_ready held high the block runs at one beat
// per cycle indefinitely. The descriptor table is a TYPE_COUNT-entry memory
// looked up on the first header byte; its registered entry is used by the
// second byte, and a descriptor write to the same type in between is
// forwarded. Known bits are flops cleared by reset, so there is no clearing
// pass. Results are registered into the result queue behind any waiting
// beats; a good header gives two result beats, every other stream byte one
// (the first header byte gives none). After a header error every stream
// byte comes out as dropped until reset.
module message_type_length_deframer #(
   parameter int TYPE_COUNT       = 256,
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic [mtld_pkg::BYTE_W-1:0] req_data_byte,
   input  logic [mtld_pkg::BYTE_W-1:0] req_desc_id,
   input  logic                        req_desc_valid,
   input  logic                        req_desc_variable,
   input  logic [mtld_pkg::SIZE_W-1:0] req_desc_size,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [mtld_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic [mtld_pkg::BYTE_W-1:0] rsp_msg_type,
   output logic                        rsp_first_of_msg,
   output logic                        rsp_last_of_msg,
   output logic [1:0]                  rsp_status
);
   import mtld_pkg::*;

   logic       in_acc;
   logic       item_en;
   logic       pop;
   logic [1:0] push_cnt;
   tbl_wr_type tbl_wr;
   tbl_rd_type tbl_rd;
   desc_type   entry;
   rsp_type    rsp0, rsp1, head;

   assign in_acc  = req_valid && req_ready;
   assign item_en = in_acc && !req_type;
   assign pop     = rsp_valid && rsp_ready;

   assign tbl_wr.en            = in_acc && req_type;
   assign tbl_wr.id            = req_desc_id;
   assign tbl_wr.desc.known    = req_desc_valid;
   assign tbl_wr.desc.variable = req_desc_variable;
   assign tbl_wr.desc.size     = req_desc_size;

   mtld_desc_tbl #(
      .TYPE_COUNT(TYPE_COUNT)
   ) u_tbl (
      .clock (clock),
      .reset (reset),
      .wr    (tbl_wr),
      .rd    (tbl_rd),
      .entry (entry)
   );

   mtld_parse #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .item_en   (item_en),
      .data_byte (req_data_byte),
      .entry     (entry),
      .rd        (tbl_rd),
      .push_cnt  (push_cnt),
      .rsp0      (rsp0),
      .rsp1      (rsp1)
   );

   mtld_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .rsp0      (rsp0),
      .rsp1      (rsp1),
      .pop       (pop),
      .out_valid (rsp_valid),
      .head      (head),
      .room      (req_ready)
   );

   assign rsp_out_byte     = head.out_byte;
   assign rsp_msg_type     = head.msg_type;
   assign rsp_first_of_msg = head.first_of_msg;
   assign rsp_last_of_msg  = head.last_of_msg;
   assign rsp_status       = head.status;

endmodule

[rtl/core/mtld_desc_tbl.sv]
// Descriptor table: entry memory, per-type known bits and write forwarding.
module mtld_desc_tbl #(
   parameter int TYPE_COUNT = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mtld_pkg::tbl_wr_type wr,
   input  mtld_pkg::tbl_rd_type rd,
   output mtld_pkg::desc_type   entry
);
   import mtld_pkg::*;

   localparam int AW = $clog2(TYPE_COUNT);
   localparam int EW = SIZE_W + 1;

   logic [EW-1:0]         mem [TYPE_COUNT];
   logic [TYPE_COUNT-1:0] known_ff;
   logic [EW-1:0]         q_ff;
   logic [BYTE_W-1:0]     rd_id_ff;
   logic                  wr_ok;
   logic                  rd_ok;
   logic [EW-1:0]         wr_data;

   assign wr_ok   = {1'b0, wr.id} < (BYTE_W+1)'(TYPE_COUNT);
   assign rd_ok   = {1'b0, rd_id_ff} < (BYTE_W+1)'(TYPE_COUNT);
   assign wr_data = {wr.desc.variable, wr.desc.size};

   // q_ff always mirrors the entry of the last type looked up; a later write to
   // that type is forwarded so the second header byte sees the newest value.
   always_ff @(posedge clock) begin
      if (wr.en && wr_ok) begin
         mem[wr.id[AW-1:0]] <= wr_data;
      end
      if (rd.en) begin
         q_ff     <= mem[rd.id[AW-1:0]];
         rd_id_ff <= rd.id;
      end else if (wr.en && wr_ok && (wr.id == rd_id_ff)) begin
         q_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= '0;
      end else if (wr.en && wr_ok) begin
         known_ff[wr.id[AW-1:0]] <= wr.desc.known;
      end
   end

   assign entry.known    = rd_ok && known_ff[rd_id_ff[AW-1:0]];
   assign entry.variable = q_ff[EW-1];
   assign entry.size     = q_ff[SIZE_W-1:0];

   a_fwd_hit : assert property (@(posedge clock) disable iff (reset)
      (!rd.en && wr.en && wr_ok && (wr.id == rd_id_ff)) |=> (q_ff == $past(wr_data)))
      else $error("descriptor write not forwarded to pending lookup");

endmodule

[rtl/core/mtld_parse.sv]
// Header check, length field capture and message byte tagging.
module mtld_parse #(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_en,
   input  logic [mtld_pkg::BYTE_W-1:0] data_byte,
   input  mtld_pkg::desc_type          entry,
   output mtld_pkg::tbl_rd_type        rd,
   output logic [1:0]                  push_cnt,
   output mtld_pkg::rsp_type           rsp0,
   output mtld_pkg::rsp_type           rsp1
);
   import mtld_pkg::*;

   localparam int LL_W  = $clog2(MAX_LENGTH_BYTES + 1);
   localparam int LI_W  = (MAX_LENGTH_BYTES > 1) ? $clog2(MAX_LENGTH_BYTES) : 1;
   localparam int ACC_W = BYTE_W * MAX_LENGTH_BYTES;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] held_ff, held_in;
   logic [LL_W-1:0]   len_left_ff, len_left_in;
   logic [LI_W-1:0]   len_idx_ff, len_idx_in;
   logic [ACC_W-1:0]  acc_ff, acc_in, acc_upd;
   logic [BODY_W-1:0] body_ff, body_in;

   logic              hdr_mismatch;
   logic              hdr_last;
   logic [SIZE_W-1:0] fixed_size;
   logic [LL_W-1:0]   len_sat;
   logic              len_done;
   logic              len_zero;
   logic              body_last;

   always_comb begin
      acc_upd = acc_ff;
      for (int k = 0; k < MAX_LENGTH_BYTES; k++) begin
         if (len_idx_ff == LI_W'(k)) begin
            acc_upd[k*BYTE_W +: BYTE_W] = data_byte;
         end
      end
   end

   assign hdr_mismatch = data_byte != held_ff;
   assign fixed_size   = (entry.size < SIZE_W'(2)) ? SIZE_W'(2) : entry.size;
   assign len_sat      = (entry.size > SIZE_W'(MAX_LENGTH_BYTES)) ?
                         LL_W'(MAX_LENGTH_BYTES) : entry.size[LL_W-1:0];
   assign hdr_last     = entry.variable ? (entry.size == '0) : (entry.size <= SIZE_W'(2));
   assign len_done     = len_left_ff == LL_W'(1);
   assign len_zero     = acc_upd == '0;
   assign body_last    = body_ff == BODY_W'(1);

   assign rd.en = item_en && (phase_ff == PH_HEAD0);
   assign rd.id = data_byte;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (item_en) begin
         unique case (phase_ff)
            PH_HEAD0: phase_in = PH_HEAD1;
            PH_HEAD1: begin
               if (hdr_mismatch || !entry.known) begin
                  phase_in = PH_HALT;
               end else if (hdr_last) begin
                  phase_in = PH_HEAD0;
               end else if (entry.variable) begin
                  phase_in = PH_LEN;
               end else begin
                  phase_in = PH_BODY;
               end
            end
            PH_LEN: begin
               if (len_done) begin
                  phase_in = len_zero ? PH_HEAD0 : PH_BODY;
               end
            end
            PH_BODY: begin
               if (body_last) begin
                  phase_in = PH_HEAD0;
               end
            end
            PH_HALT: phase_in = PH_HALT;
            default: phase_in = PH_HALT;
         endcase
      end
   end

   // counters and held header
   always_comb begin
      held_in     = held_ff;
      len_left_in = len_left_ff;
      len_idx_in  = len_idx_ff;
      acc_in      = acc_ff;
      body_in     = body_ff;
      if (item_en) begin
         case (phase_ff)
            PH_HEAD0: held_in = data_byte;
            PH_HEAD1: begin
               if (entry.variable) begin
                  len_left_in = len_sat;
                  len_idx_in  = '0;
                  acc_in      = '0;
               end else begin
                  body_in = BODY_W'(fixed_size) - BODY_W'(2);
               end
            end
            PH_LEN: begin
               acc_in      = acc_upd;
               len_idx_in  = len_idx_ff + LI_W'(1);
               len_left_in = len_left_ff - LL_W'(1);
               if (len_done) begin
                  body_in = BODY_W'(acc_upd);
               end
            end
            PH_BODY: body_in = body_ff - BODY_W'(1);
            default: ;
         endcase
      end
   end

   // results
   always_comb begin
      push_cnt = 2'd0;
      rsp0     = '{out_byte: data_byte, msg_type: held_ff, first_of_msg: 1'b0,
                   last_of_msg: 1'b0, status: ST_OK};
      rsp1     = '{out_byte: data_byte, msg_type: held_ff, first_of_msg: 1'b0,
                   last_of_msg: hdr_last, status: ST_OK};
      if (item_en) begin
         unique case (phase_ff)
            PH_HEAD0: push_cnt = 2'd0;
            PH_HEAD1: begin
               if (hdr_mismatch) begin
                  push_cnt    = 2'd1;
                  rsp0.status = ST_MISMATCH;
               end else if (!entry.known) begin
                  push_cnt    = 2'd1;
                  rsp0.status = ST_UNKNOWN;
               end else begin
                  push_cnt          = 2'd2;
                  rsp0.out_byte     = held_ff;
                  rsp0.first_of_msg = 1'b1;
               end
            end
            PH_LEN: begin
               push_cnt         = 2'd1;
               rsp0.last_of_msg = len_done && len_zero;
            end
            PH_BODY: begin
               push_cnt         = 2'd1;
               rsp0.last_of_msg = body_last;
            end
            PH_HALT: begin
               push_cnt      = 2'd1;
               rsp0.msg_type = '0;
               rsp0.status   = ST_DROPPED;
            end
            default: begin
               push_cnt      = 2'd1;
               rsp0.msg_type = '0;
               rsp0.status   = ST_DROPPED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEAD0;
         held_ff     <= '0;
         len_left_ff <= '0;
         len_idx_ff  <= '0;
         acc_ff      <= '0;
         body_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         len_left_ff <= len_left_in;
         len_idx_ff  <= len_idx_in;
         acc_ff      <= acc_in;
         body_ff     <= body_in;
      end
   end

   a_halt_sticky : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HALT) |=> (phase_ff == PH_HALT))
      else $error("left halt without reset");

   a_pair_on_header : assert property (@(posedge clock) disable iff (reset)
      (push_cnt == 2'd2) |-> (item_en && (phase_ff == PH_HEAD1) && !hdr_mismatch))
      else $error("two results outside a good header");

   a_body_nonzero : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (body_ff != '0))
      else $error("body phase with zero bytes left");

endmodule

[rtl/core/mtld_rsp_fifo.sv]
// Small result queue taking up to two beats per cycle and giving one.
module mtld_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_cnt,
   input  mtld_pkg::rsp_type rsp0,
   input  mtld_pkg::rsp_type rsp1,
   input  logic              pop,
   output logic              out_valid,
   output mtld_pkg::rsp_type head,
   output logic              room
);
   import mtld_pkg::*;

   rsp_type               ent_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic [FIFO_PTR_W-1:0] wr_ptr_nx;

   assign wr_ptr_nx = wr_ptr_ff + FIFO_PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign count_in  = count_ff + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);

   assign out_valid = count_ff != '0;
   assign head      = ent_ff[rd_ptr_ff];
   // two free slots so a good header can always land both beats
   assign room      = count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         ent_ff[wr_ptr_ff] <= rsp0;
      end
      if (push_cnt == 2'd2) begin
         ent_ff[wr_ptr_nx] <= rsp1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
      else $error("push without room");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the message type/length deframer.
module tb_top;
   import mtld_pkg::*;

   localparam int TYPES     = 256;
   localparam int LEN_MAX   = 4;
   localparam int ITEMS     = 1900;
   localparam int TAIL_WAIT = 20;

   typedef struct {
      logic              kind;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] id;
      logic              known;
      logic              variable;
      logic [SIZE_W-1:0] size;
      bit                drain_first;
   } stream_beat_type;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic              req_type = 0;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic [BYTE_W-1:0] req_desc_id = '0;
   logic              req_desc_valid = 0;
   logic              req_desc_variable = 0;
   logic [SIZE_W-1:0] req_desc_size = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic [BYTE_W-1:0] rsp_msg_type;
   logic              rsp_first_of_msg;
   logic              rsp_last_of_msg;
   logic [1:0]        rsp_status;

   message_type_length_deframer #(
      .TYPE_COUNT      (TYPES),
      .MAX_LENGTH_BYTES(LEN_MAX)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_data_byte    (req_data_byte),
      .req_desc_id      (req_desc_id),
      .req_desc_valid   (req_desc_valid),
      .req_desc_variable(req_desc_variable),
      .req_desc_size    (req_desc_size),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_msg_type     (rsp_msg_type),
      .rsp_first_of_msg (rsp_first_of_msg),
      .rsp_last_of_msg  (rsp_last_of_msg),
      .rsp_status       (rsp_status)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // stimulus plan and its own view of the descriptor table
   stream_beat_type   beats_to_send [$];
   desc_type          planned_desc [TYPES];
   logic [BYTE_W-1:0] hot_types [6] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h3C, 8'h11};
   int                n_planned = 0;
   bit                hold_next = 0;
   string             close_case;

   // predictor state
   rsp_type           expected_bytes [$];
   desc_type          desc_mirror [TYPES];
   phase_type         frame_ph = PH_HEAD0;
   logic [BYTE_W-1:0] held_type = '0;
   logic [2:0]        len_left = '0;
   logic [2:0]        len_idx = '0;
   logic [31:0]       len_acc = '0;
   logic [31:0]       body_left = '0;

   int  fail_count = 0;
   int  n_accepted = 0;
   int  n_checked = 0;
   int  n_msgs = 0;
   int  n_dropped = 0;
   int  n_desc = 0;
   bit  req_took = 0;
   wire calm = (n_accepted >= 600) && (n_accepted < 1000);

   task automatic queue_beat(input stream_beat_type sb);
      sb.drain_first = hold_next;
      hold_next = 0;
      beats_to_send.push_back(sb);
      n_planned++;
   endtask

   task automatic add_byte(input logic [BYTE_W-1:0] b);
      stream_beat_type sb;
      sb.kind = 1'b0;
      sb.data = b;
      sb.id = 8'($urandom_range(255));
      sb.known = 1'($urandom_range(1));
      sb.variable = 1'($urandom_range(1));
      sb.size = 16'($urandom_range(65535));
      queue_beat(sb);
   endtask

   task automatic add_desc(input logic [BYTE_W-1:0] id, input logic known,
                           input logic variable, input logic [SIZE_W-1:0] size);
      stream_beat_type sb;
      sb.kind = 1'b1;
      sb.data = 8'($urandom_range(255));
      sb.id = id;
      sb.known = known;
      sb.variable = variable;
      sb.size = size;
      planned_desc[id].known = known;
      planned_desc[id].variable = variable;
      planned_desc[id].size = size;
      queue_beat(sb);
   endtask

   task automatic add_noise_desc();
      logic v;
      logic [SIZE_W-1:0] sz;
      v = 1'($urandom_range(1));
      if ($urandom_range(99) < 20)
         sz = 16'($urandom_range(65535));
      else
         sz = v ? 16'($urandom_range(6)) : 16'($urandom_range(20));
      add_desc(8'($urandom_range(255)), $urandom_range(99) >= 15, v, sz);
   endtask

   // len_value < 0 picks the length value at random
   task automatic add_message(input logic [BYTE_W-1:0] t, input bit swap, input int len_value);
      int body, nlen, val;
      logic v;
      desc_type d;
      add_byte(t);
      if (swap) begin
         // rewrite the entry between the two header bytes
         v = 1'($urandom_range(1));
         add_desc(t, 1'b1, v, v ? 16'($urandom_range(6)) : 16'($urandom_range(20)));
      end
      add_byte(t);
      d = planned_desc[t];
      if (!d.variable) begin
         body = (d.size < 2) ? 0 : int'(d.size) - 2;
      end else begin
         nlen = (d.size > LEN_MAX) ? LEN_MAX : int'(d.size);
         val = len_value;
         if (nlen == 0)
            val = 0;
         else if (val < 0) begin
            if ($urandom_range(99) < 10)
               val = 0;
            else if (nlen >= 2 && $urandom_range(99) < 3)
               val = $urandom_range(600, 256);
            else
               val = $urandom_range(12, 1);
         end
         for (int i = 0; i < nlen; i++) begin
            if ($urandom_range(99) < 4)
               add_noise_desc();
            add_byte(8'(val >> (8 * i)));
         end
         body = val;
      end
      for (int i = 0; i < body; i++) begin
         if ($urandom_range(99) < 4)
            add_noise_desc();
         add_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic expect_rsp(input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] t,
                             input logic first, input logic last, input status_type st);
      rsp_type r;
      r.out_byte = b;
      r.msg_type = t;
      r.first_of_msg = first;
      r.last_of_msg = last;
      r.status = st;
      expected_bytes.push_back(r);
   endtask

   task automatic deframe_beat(input logic kind, input logic [BYTE_W-1:0] b,
                               input logic [BYTE_W-1:0] id, input logic known,
                               input logic variable, input logic [SIZE_W-1:0] size);
      desc_type d;
      logic [31:0] sz;
      logic last;
      if (kind) begin
         desc_mirror[id].known = known;
         desc_mirror[id].variable = variable;
         desc_mirror[id].size = size;
         return;
      end
      case (frame_ph)
         PH_HEAD0: begin
            held_type = b;
            frame_ph = PH_HEAD1;
         end
         PH_HEAD1: begin
            d = desc_mirror[held_type];
            if (b != held_type) begin
               expect_rsp(b, held_type, 1'b0, 1'b0, ST_MISMATCH);
               frame_ph = PH_HALT;
            end else if (!d.known) begin
               expect_rsp(b, held_type, 1'b0, 1'b0, ST_UNKNOWN);
               frame_ph = PH_HALT;
            end else begin
               if (!d.variable) begin
                  sz = (d.size < 2) ? 32'd2 : 32'(d.size);
                  body_left = sz - 2;
                  last = (body_left == 0);
                  frame_ph = last ? PH_HEAD0 : PH_BODY;
               end else begin
                  sz = (d.size > LEN_MAX) ? 32'(LEN_MAX) : 32'(d.size);
                  len_left = 3'(sz);
                  len_idx = '0;
                  len_acc = '0;
                  last = (sz == 0);
                  frame_ph = last ? PH_HEAD0 : PH_LEN;
               end
               expect_rsp(held_type, held_type, 1'b1, 1'b0, ST_OK);
               expect_rsp(b, held_type, 1'b0, last, ST_OK);
            end
         end
         PH_LEN: begin
            last = 1'b0;
            len_acc = len_acc | (32'(b) << (8 * len_idx[1:0]));
            len_idx = len_idx + 1;
            len_left = len_left - 1;
            if (len_left == 0) begin
               body_left = len_acc;
               if (body_left == 0) begin
                  last = 1'b1;
                  frame_ph = PH_HEAD0;
               end else begin
                  frame_ph = PH_BODY;
               end
            end
            expect_rsp(b, held_type, 1'b0, last, ST_OK);
         end
         PH_BODY: begin
            body_left = body_left - 1;
            last = (body_left == 0);
            if (last)
               frame_ph = PH_HEAD0;
            expect_rsp(b, held_type, 1'b0, last, ST_OK);
         end
         default: begin
            frame_ph = PH_HALT;
            expect_rsp(b, 8'h00, 1'b0, 1'b0, ST_DROPPED);
         end
      endcase
   endtask

   always @(negedge clock) begin : drive_req
      stream_beat_type nb;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 6);
         if (!req_valid || req_took) begin
            if (beats_to_send.size() != 0
                && !(beats_to_send[0].drain_first && expected_bytes.size() != 0)
                && (calm || $urandom_range(99) >= 6)) begin
               nb = beats_to_send.pop_front();
               req_type <= nb.kind;
               req_data_byte <= nb.data;
               req_desc_id <= nb.id;
               req_desc_valid <= nb.known;
               req_desc_variable <= nb.variable;
               req_desc_size <= nb.size;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch
      rsp_type got, want;
      req_took = 0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.out_byte = rsp_out_byte;
            got.msg_type = rsp_msg_type;
            got.first_of_msg = rsp_first_of_msg;
            got.last_of_msg = rsp_last_of_msg;
            got.status = status_type'(rsp_status);
            if (expected_bytes.size() == 0) begin
               $error("unexpected result beat: out_byte %02h status %0d",
                      got.out_byte, got.status);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               n_checked++;
               if (want.first_of_msg) n_msgs++;
               if (want.status == ST_DROPPED) n_dropped++;
               if (got.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                  fail_count++;
               end
               if (got.msg_type !== want.msg_type) begin
                  $error("msg_type: expected %02h, got %02h", want.msg_type, got.msg_type);
                  fail_count++;
               end
               if (got.first_of_msg !== want.first_of_msg) begin
                  $error("first_of_msg: expected %0b, got %0b",
                         want.first_of_msg, got.first_of_msg);
                  fail_count++;
               end
               if (got.last_of_msg !== want.last_of_msg) begin
                  $error("last_of_msg: expected %0b, got %0b",
                         want.last_of_msg, got.last_of_msg);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            req_took = 1;
            n_accepted++;
            if (req_type) n_desc++;
            deframe_beat(req_type, req_data_byte, req_desc_id, req_desc_valid,
                         req_desc_variable, req_desc_size);
         end
      end
   end

   initial begin : stimulus
      logic [BYTE_W-1:0] t;
      bit drain_set;
      drain_set = 0;
      for (int i = 0; i < TYPES; i++) begin
         planned_desc[i] = '0;
         desc_mirror[i] = '0;
      end

      // directed: size floor, length count saturation, empty length field,
      // zero length value, entry rewritten between the header bytes
      add_desc(8'h00, 1'b1, 1'b0, 16'd0);
      add_desc(8'hFF, 1'b1, 1'b0, 16'd1);
      add_desc(8'h5A, 1'b1, 1'b1, 16'hFFFF);
      add_desc(8'hA5, 1'b1, 1'b1, 16'd0);
      add_desc(8'h3C, 1'b1, 1'b1, 16'd2);
      add_desc(8'h11, 1'b1, 1'b0, 16'd5);
      add_message(8'h00, 1'b0, -1);
      add_message(8'hFF, 1'b0, -1);
      add_message(8'hA5, 1'b0, -1);
      add_message(8'h5A, 1'b0, 0);
      add_message(8'h11, 1'b1, -1);

      while (n_planned < ITEMS) begin
         if (!drain_set && n_planned >= ITEMS / 2) begin
            hold_next = 1;
            drain_set = 1;
         end
         if ($urandom_range(99) < 8)
            add_noise_desc();
         t = ($urandom_range(99) < 30) ? 8'($urandom_range(255)) : hot_types[$urandom_range(5)];
         if (!planned_desc[t].known || (!planned_desc[t].variable && planned_desc[t].size > 64)) begin
            if ($urandom_range(1))
               add_desc(t, 1'b1, 1'b1, 16'($urandom_range(6)));
            else
               add_desc(t, 1'b1, 1'b0, 16'($urandom_range(20)));
         end
         add_message(t, $urandom_range(99) < 5, -1);
      end

      // a header error halts the block for good, so only one can close the run
      t = 8'($urandom_range(255));
      if ($urandom_range(1)) begin
         close_case = "header mismatch";
         add_byte(t);
         add_byte(t ^ 8'($urandom_range(255, 1)));
      end else begin
         close_case = "unknown type";
         add_desc(t, 1'b0, 1'($urandom_range(1)), 16'($urandom_range(65535)));
         add_byte(t);
         add_byte(t);
      end
      for (int i = 0; i < 24; i++) begin
         if ($urandom_range(99) < 25)
            add_noise_desc();
         else
            add_byte(8'($urandom_range(255)));
      end

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      @(posedge clock);
      #1;
      while (beats_to_send.size() != 0 || req_valid || expected_bytes.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (TAIL_WAIT) @(posedge clock);
      #1;

      $display("run: %0d beats in, %0d result beats checked, %0d messages, %0d descriptor writes",
               n_accepted, n_checked, n_msgs, n_desc);
      $display("run closed by a %s, then %0d bytes came out dropped", close_case, n_dropped);
      if (fail_count == 0)
         $display("** message_type_length_deframer: PASSED **");
      else
         $display("** message_type_length_deframer: FAILED **");
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("timeout: %0d beats in, %0d results still expected",
               n_accepted, expected_bytes.size());
      $display("** message_type_length_deframer: FAILED **");
      $finish;
   end

endmodule
